### src/dlq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlq_pkg: shared types and constants for the delta-list timer queue
// Holds the action and result codes, cell commands, controller states and
// the link structs that run between neighboring cells.
// ----------------------------------------------------------------------------
package dlq_pkg;

  localparam int PID_W       = 8;
  localparam int DELTA_W     = 16;
  localparam int MAX_RESULTS = 16;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);
  localparam int RES_IDX_W   = $clog2(MAX_RESULTS);
  localparam int IN_DATA_W   = 32;
  localparam int OUT_DATA_W  = 32;
  localparam int KIND_W      = 3;
  localparam int OUT_CNT_W   = 5;

  // Input actions
  typedef enum logic [1:0] {
    ACT_ADD     = 2'd0,
    ACT_TICK    = 2'd1,
    ACT_RM_HEAD = 2'd2,
    ACT_RM_TAIL = 2'd3
  } action_t;

  // Result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_ADDED    = 3'd0,
    KIND_FULL     = 3'd1,
    KIND_RELEASED = 3'd2,
    KIND_NONE     = 3'd3,
    KIND_REMOVED  = 3'd4,
    KIND_EMPTY    = 3'd5
  } kind_t;

  // Commands broadcast to every cell
  typedef enum logic [2:0] {
    OP_HOLD   = 3'd0,
    OP_LAUNCH = 3'd1,
    OP_WALK   = 3'd2,
    OP_INSERT = 3'd3,
    OP_DEC    = 3'd4,
    OP_POP    = 3'd5,
    OP_DROP   = 3'd6
  } cell_op_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_EXEC    = 3'd1,
    ST_WALK    = 3'd2,
    ST_INSERT  = 3'd3,
    ST_RELEASE = 3'd4,
    ST_EMIT    = 3'd5
  } state_t;

  typedef struct packed {
    cell_op_t           op;
    logic [PID_W-1:0]   new_pid;
    logic [DELTA_W-1:0] launch_rem;
  } cell_cmd_t;

  // Cell to its right-hand neighbor
  typedef struct packed {
    logic               valid;
    logic [PID_W-1:0]   pid;
    logic [DELTA_W-1:0] delta;
    logic               probe_v;
    logic [DELTA_W-1:0] probe_rem;
    logic               fwd_v;
    logic [DELTA_W-1:0] fwd_rem;
  } fwd_link_t;

  // Cell to its left-hand neighbor
  typedef struct packed {
    logic               valid;
    logic [PID_W-1:0]   pid;
    logic [DELTA_W-1:0] delta;
  } back_link_t;

  // Chain status seen by the controller
  typedef struct packed {
    logic             head_valid;
    logic [PID_W-1:0] head_pid;
    logic             head_zero;
    logic [PID_W-1:0] tail_pid;
    logic             any_stop;
  } chain_status_t;

endpackage

### src/delta_list_sleep_timer_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delta_list_sleep_timer_queue_core: delta-list sleep timer queue
// Sleeping process ids kept in wake-up order in a chain of cells, each entry
// holding its wait minus the waits ahead of it.
//
//   channel   | dir | fields
//   ----------+-----+--------------------------------------------------------
//   s_axis    | in  | tdata: action, process_id, delay
//   m_axis    | out | tdata: out_process_id, head_valid, head_process_id,
//             |     |        tail_process_id, entry_count
//             |     | tuser: result_kind; tlast: last_of_run
//
// One item at a time. Remove and rejected add: execute, then hand out the result.
// Add: launch, probe walk (one cell per cycle) to the insert position, insert, emit.
// Tick: decrement, release of each run-out head entry, then the results are handed out.
// Reset (rst, synchronous) empties the list at once; no clearing pass.
// A stalled m_tready holds the output register; the next item is taken once
// the last result of an item has entered it.
// ----------------------------------------------------------------------------
module delta_list_sleep_timer_queue_core
  import dlq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // action[1:0], process_id[9:2], delay[25:10]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // out_process_id[7:0], head_valid[8],
                                           // head_process_id[16:9],
                                           // tail_process_id[24:17], entry_count[29:25]
  output logic [KIND_W-1:0]     m_tuser,   // result_kind[2:0]
  output logic                  m_tlast    // last_of_run
);

  cell_cmd_t     cmd;
  chain_status_t status;
  fwd_link_t     fwd  [QUEUE_DEPTH+1];
  back_link_t    back [QUEUE_DEPTH+1];
  logic          stop [QUEUE_DEPTH];
  logic [PID_W-1:0] tail_sel [QUEUE_DEPTH];

  logic                 out_head_valid;
  logic [PID_W-1:0]     out_pid, out_head_pid, out_tail_pid;
  logic [OUT_CNT_W-1:0] out_count;

  // Chain ends
  assign fwd[0]            = '0;
  assign back[QUEUE_DEPTH] = '0;

  // Row of cells
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    dlq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .first      (i == 0),
      .cmd        (cmd),
      .from_left  (fwd[i]),
      .from_right (back[i+1]),
      .to_right   (fwd[i+1]),
      .to_left    (back[i]),
      .stop       (stop[i]),
      .tail_pid   (tail_sel[i])
    );
  end

  // Status gathered from the chain
  always_comb begin
    status.head_valid = fwd[1].valid;
    status.head_pid   = fwd[1].pid;
    status.head_zero  = (fwd[1].delta == '0);
    status.tail_pid   = '0;
    status.any_stop   = 1'b0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      status.tail_pid = status.tail_pid | tail_sel[i];
      status.any_stop = status.any_stop | stop[i];
    end
  end

  dlq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_tvalid),
    .in_ready       (s_tready),
    .in_action      (s_tdata[1:0]),
    .in_pid         (s_tdata[9:2]),
    .in_delay       (s_tdata[25:10]),
    .status         (status),
    .cmd            (cmd),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .out_last       (m_tlast),
    .out_kind       (m_tuser),
    .out_pid        (out_pid),
    .out_head_valid (out_head_valid),
    .out_head_pid   (out_head_pid),
    .out_tail_pid   (out_tail_pid),
    .out_count      (out_count)
  );

  // Result packing
  assign m_tdata = {2'b00, out_count, out_tail_pid, out_head_pid, out_head_valid, out_pid};

endmodule

### src/dlq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlq_cell: one list slot of the delta-list chain
// Holds a process id, its delta and a valid bit. Shifts toward the head on a
// pop, toward the tail behind the insert point, and carries the insert probe
// one slot per cycle while it searches for its position.
// ----------------------------------------------------------------------------
module dlq_cell
  import dlq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       first,
  input  cell_cmd_t  cmd,
  input  fwd_link_t  from_left,
  input  back_link_t from_right,
  output fwd_link_t  to_right,
  output back_link_t to_left,
  output logic       stop,
  output logic [PID_W-1:0] tail_pid
);

  logic               valid;
  logic [PID_W-1:0]   pid;
  logic [DELTA_W-1:0] delta;
  logic               probe_v;
  logic [DELTA_W-1:0] probe_rem;
  logic               passed;
  logic [DELTA_W:0]   pop_sum;
  logic [DELTA_W-1:0] pop_sat;

  // Probe stops here at the first slot that is empty or not below it
  always_comb begin
    stop = probe_v && (!valid || (delta >= probe_rem));
    to_right.valid     = valid;
    to_right.pid       = pid;
    to_right.delta     = delta;
    to_right.probe_v   = probe_v;
    to_right.probe_rem = probe_rem;
    to_right.fwd_v     = probe_v && !stop;
    to_right.fwd_rem   = probe_rem - delta;
    to_left.valid      = valid;
    to_left.pid        = pid;
    to_left.delta      = delta;
    tail_pid = (valid && !from_right.valid) ? pid : '0;
  end

  // Head pop folds the old head delta into the successor, saturating
  always_comb begin
    pop_sum = {1'b0, delta} + {1'b0, from_right.delta};
    pop_sat = pop_sum[DELTA_W] ? '1 : pop_sum[DELTA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= 1'b0;
      probe_v <= 1'b0;
      passed  <= 1'b0;
    end else begin
      case (cmd.op)
        OP_LAUNCH: begin
          probe_v   <= first;
          probe_rem <= cmd.launch_rem;
          passed    <= 1'b0;
        end
        OP_WALK: begin
          if (!stop) begin
            probe_v   <= from_left.fwd_v;
            probe_rem <= from_left.fwd_rem;
            if (probe_v) begin
              passed <= 1'b1;
            end
          end
        end
        OP_INSERT: begin
          probe_v <= 1'b0;
          if (probe_v) begin
            pid   <= cmd.new_pid;
            delta <= probe_rem;
            valid <= 1'b1;
          end else if (!passed) begin
            pid   <= from_left.pid;
            delta <= from_left.probe_v ? (from_left.delta - from_left.probe_rem)
                                       : from_left.delta;
            valid <= from_left.valid;
          end
        end
        OP_DEC: begin
          if (first && (delta != '0)) begin
            delta <= delta - 1'b1;
          end
        end
        OP_POP: begin
          pid   <= from_right.pid;
          valid <= from_right.valid;
          delta <= first ? pop_sat : from_right.delta;
        end
        OP_DROP: begin
          valid <= valid && from_right.valid;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### src/dlq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlq_ctrl: sequencer, result buffer and output register
// Runs one item at a time through the cell chain, collects its results and
// then hands them out with the list state left after the whole item.
// ----------------------------------------------------------------------------
module dlq_ctrl
  import dlq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_action,
  input  logic [PID_W-1:0]    in_pid,
  input  logic [DELTA_W-1:0]  in_delay,
  input  chain_status_t       status,
  output cell_cmd_t           cmd,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_last,
  output logic [KIND_W-1:0]   out_kind,
  output logic [PID_W-1:0]    out_pid,
  output logic                out_head_valid,
  output logic [PID_W-1:0]    out_head_pid,
  output logic [PID_W-1:0]    out_tail_pid,
  output logic [OUT_CNT_W-1:0] out_count
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  state_t               state, state_next;
  action_t              act;
  logic [PID_W-1:0]     act_pid;
  logic [DELTA_W-1:0]   act_delay;
  logic [CW-1:0]        cnt;
  kind_t                res_kind [MAX_RESULTS];
  logic [PID_W-1:0]     res_pid  [MAX_RESULTS];
  logic [RES_CNT_W-1:0] n_res;
  logic [RES_IDX_W-1:0] rd_ptr;

  logic                 wr_en;
  kind_t                wr_kind;
  logic [PID_W-1:0]     wr_pid;
  logic                 cnt_inc, cnt_dec;
  logic                 emit;
  logic                 last_res;
  logic                 accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign last_res = (RES_CNT_W'(rd_ptr) + RES_CNT_W'(1)) == n_res;

  // Next state, cell command and result writes
  always_comb begin
    state_next     = state;
    cmd.op         = OP_HOLD;
    cmd.new_pid    = act_pid;
    cmd.launch_rem = (act_delay == '0) ? DELTA_W'(1) : act_delay;
    wr_en          = 1'b0;
    wr_kind        = KIND_ADDED;
    wr_pid         = '0;
    cnt_inc        = 1'b0;
    cnt_dec        = 1'b0;
    emit           = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (act)
          ACT_ADD: begin
            if (cnt == CW'(QUEUE_DEPTH)) begin
              wr_en      = 1'b1;
              wr_kind    = KIND_FULL;
              state_next = ST_EMIT;
            end else begin
              cmd.op     = OP_LAUNCH;
              state_next = ST_WALK;
            end
          end
          ACT_TICK: begin
            cmd.op     = OP_DEC;
            state_next = ST_RELEASE;
          end
          ACT_RM_HEAD: begin
            wr_en      = 1'b1;
            state_next = ST_EMIT;
            if (cnt == '0) begin
              wr_kind = KIND_EMPTY;
            end else begin
              wr_kind = KIND_REMOVED;
              wr_pid  = status.head_pid;
              cmd.op  = OP_POP;
              cnt_dec = 1'b1;
            end
          end
          ACT_RM_TAIL: begin
            wr_en      = 1'b1;
            state_next = ST_EMIT;
            if (cnt == '0) begin
              wr_kind = KIND_EMPTY;
            end else begin
              wr_kind = KIND_REMOVED;
              wr_pid  = status.tail_pid;
              cmd.op  = OP_DROP;
              cnt_dec = 1'b1;
            end
          end
          default: begin
            state_next = ST_IDLE;
          end
        endcase
      end
      ST_WALK: begin
        cmd.op = OP_WALK;
        if (status.any_stop) begin
          state_next = ST_INSERT;
        end
      end
      ST_INSERT: begin
        cmd.op     = OP_INSERT;
        cnt_inc    = 1'b1;
        wr_en      = 1'b1;
        wr_kind    = KIND_ADDED;
        state_next = ST_EMIT;
      end
      ST_RELEASE: begin
        // One release per cycle while the head has run out and the result buffer has room
        if (status.head_valid && status.head_zero &&
            (n_res < RES_CNT_W'(MAX_RESULTS))) begin
          wr_en   = 1'b1;
          wr_kind = KIND_RELEASED;
          wr_pid  = status.head_pid;
          cmd.op  = OP_POP;
          cnt_dec = 1'b1;
        end else begin
          if (n_res == '0) begin
            wr_en   = 1'b1;
            wr_kind = KIND_NONE;
          end
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid || out_ready) begin
          emit = 1'b1;
          if (last_res) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      n_res     <= '0;
      rd_ptr    <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cnt_inc) begin
        cnt <= cnt + 1'b1;
      end else if (cnt_dec) begin
        cnt <= cnt - 1'b1;
      end
      if (accept) begin
        n_res  <= '0;
        rd_ptr <= '0;
      end else begin
        if (wr_en) begin
          n_res <= n_res + 1'b1;
        end
        if (emit) begin
          rd_ptr <= rd_ptr + 1'b1;
        end
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Item latch and result buffer
  always_ff @(posedge clk) begin
    if (accept) begin
      act       <= action_t'(in_action);
      act_pid   <= in_pid;
      act_delay <= in_delay;
    end
    if (wr_en) begin
      res_kind[n_res[RES_IDX_W-1:0]] <= wr_kind;
      res_pid[n_res[RES_IDX_W-1:0]]  <= wr_pid;
    end
  end

  // Output register; list state is stable for the whole emit phase
  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind       <= res_kind[rd_ptr];
      out_pid        <= res_pid[rd_ptr];
      out_last       <= last_res;
      out_head_valid <= status.head_valid;
      out_head_pid   <= status.head_valid ? status.head_pid : '0;
      out_tail_pid   <= status.tail_pid;
      out_count      <= OUT_CNT_W'(cnt);
    end
  end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for delta_list_sleep_timer_queue_core
// Drives add, tick and remove items into the timer queue and checks every
// result against a behavioral copy of the delta list kept in the bench.
// Directed items cover a full list, equal wake times, zero delay, middle and
// tail inserts and the empty list. Random traffic then runs in phases with
// and without sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb;
  import dlq_pkg::*;

  localparam int QDEPTH     = 16;
  localparam int DRAIN_WAIT = 40;

  // One result item as seen on the master side
  typedef struct {
    kind_t            kind;
    logic [PID_W-1:0] pid;
    logic             last;
    logic             head_valid;
    logic [PID_W-1:0] head_pid;
    logic [PID_W-1:0] tail_pid;
    logic [4:0]       fill;
  } sleep_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [KIND_W-1:0]     m_tuser;
  logic                  m_tlast;

  // Bench copy of the delta list
  logic [PID_W-1:0]   model_pid [QDEPTH];
  logic [DELTA_W-1:0] model_delta [QDEPTH];
  int                 model_count = 0;

  sleep_result_t pending_results [$];
  sleep_result_t want;

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int mismatches     = 0;
  int items_sent     = 0;
  int results_checked = 0;
  int n_adds = 0, n_ticks = 0, n_removes = 0, n_released = 0, peak_fill = 0;

  delta_list_sleep_timer_queue_core #(.QUEUE_DEPTH(QDEPTH)) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  task automatic report_mismatch(string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, int got, int exp_val);
    if (got != exp_val)
      report_mismatch($sformatf("result %0d field %s: got %0d, wanted %0d",
                                results_checked, name, got, exp_val));
  endtask

  // Result checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: kind %0d pid %0d",
                                  m_tuser, m_tdata[7:0]));
      end else begin
        want = pending_results.pop_front();
        check_field("result_kind", m_tuser, want.kind);
        check_field("out_process_id", m_tdata[7:0], want.pid);
        check_field("last_of_run", m_tlast, want.last);
        check_field("head_valid", m_tdata[8], want.head_valid);
        check_field("head_process_id", m_tdata[16:9], want.head_pid);
        check_field("tail_process_id", m_tdata[24:17], want.tail_pid);
        check_field("entry_count", m_tdata[29:25], want.fill);
      end
      results_checked++;
    end
  end

  function automatic sleep_result_t make_result(kind_t kind, logic [PID_W-1:0] pid);
    sleep_result_t r;
    r.kind       = kind;
    r.pid        = pid;
    r.last       = 1'b0;
    r.head_valid = 1'b0;
    r.head_pid   = '0;
    r.tail_pid   = '0;
    r.fill       = '0;
    return r;
  endfunction

  // Pop the head; its remaining delta moves onto the successor, saturating
  function automatic void pop_model_head();
    int sum;
    int i;
    if (model_count == 0) return;
    if (model_count > 1) begin
      sum = int'(model_delta[0]) + int'(model_delta[1]);
      model_delta[1] = (sum > 65535) ? 16'hFFFF : sum[15:0];
    end
    for (i = 1; i < model_count; i++) begin
      model_pid[i-1]   = model_pid[i];
      model_delta[i-1] = model_delta[i];
    end
    model_count--;
  endfunction

  // Work out the results of one accepted item and queue them
  task automatic predict_timer_step(action_t act, logic [PID_W-1:0] pid,
                                    logic [DELTA_W-1:0] dly);
    sleep_result_t batch [$];
    int rem;
    int pos;
    int i;
    int k;
    logic [PID_W-1:0] p;
    case (act)
      ACT_ADD: begin
        n_adds++;
        if (model_count >= QDEPTH) begin
          batch.push_back(make_result(KIND_FULL, '0));
        end else begin
          rem = (dly == 0) ? 1 : int'(dly);
          pos = 0;
          // equal wake time stops the walk, so the new entry goes first
          while (pos < model_count && int'(model_delta[pos]) < rem) begin
            rem -= model_delta[pos];
            pos++;
          end
          if (pos < model_count) model_delta[pos] = model_delta[pos] - rem[15:0];
          for (i = model_count; i > pos; i--) begin
            model_pid[i]   = model_pid[i-1];
            model_delta[i] = model_delta[i-1];
          end
          model_pid[pos]   = pid;
          model_delta[pos] = rem[15:0];
          model_count++;
          batch.push_back(make_result(KIND_ADDED, '0));
        end
      end
      ACT_TICK: begin
        n_ticks++;
        if (model_count > 0 && model_delta[0] > 0) model_delta[0]--;
        while (model_count > 0 && model_delta[0] == 0 && batch.size() < MAX_RESULTS) begin
          p = model_pid[0];
          pop_model_head();
          batch.push_back(make_result(KIND_RELEASED, p));
          n_released++;
        end
        if (batch.size() == 0) batch.push_back(make_result(KIND_NONE, '0));
      end
      ACT_RM_HEAD: begin
        n_removes++;
        if (model_count == 0) begin
          batch.push_back(make_result(KIND_EMPTY, '0));
        end else begin
          p = model_pid[0];
          pop_model_head();
          batch.push_back(make_result(KIND_REMOVED, p));
        end
      end
      default: begin
        n_removes++;
        if (model_count == 0) begin
          batch.push_back(make_result(KIND_EMPTY, '0));
        end else begin
          p = model_pid[model_count-1];
          model_count--;
          batch.push_back(make_result(KIND_REMOVED, p));
        end
      end
    endcase
    if (model_count > peak_fill) peak_fill = model_count;
    // state after the whole step goes into every result of the step
    for (k = 0; k < batch.size(); k++) begin
      batch[k].last       = (k == batch.size() - 1);
      batch[k].head_valid = (model_count > 0);
      batch[k].head_pid   = (model_count > 0) ? model_pid[0] : '0;
      batch[k].tail_pid   = (model_count > 0) ? model_pid[model_count-1] : '0;
      batch[k].fill       = 5'(model_count);
      pending_results.push_back(batch[k]);
    end
  endtask

  // Send one item; valid stays high on return so back-to-back items need no drop
  task automatic send_item(action_t act, logic [PID_W-1:0] pid, logic [DELTA_W-1:0] dly);
    int gap;
    gap = 0;
    while ($urandom_range(99) < src_idle_pct) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, dly, pid, act};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_timer_step(act, pid, dly);
    items_sent++;
  endtask

  function automatic action_t pick_action();
    int r;
    r = $urandom_range(99);
    if (r < 45) return ACT_ADD;
    if (r < 80) return ACT_TICK;
    if (r < 90) return ACT_RM_HEAD;
    return ACT_RM_TAIL;
  endfunction

  // Mostly short sleeps so ticks release often; a few full-range delays
  function automatic logic [DELTA_W-1:0] pick_delay();
    int r;
    r = $urandom_range(99);
    if (r < 5)  return '0;
    if (r < 70) return DELTA_W'($urandom_range(6, 1));
    if (r < 90) return DELTA_W'($urandom_range(40));
    return DELTA_W'($urandom_range(65535));
  endfunction

  // Fill the list with equal wake times, overflow it, release all at once
  task automatic test_full_list();
    int i;
    for (i = 0; i < QDEPTH; i++)
      send_item(ACT_ADD, PID_W'(i * 17), DELTA_W'(i % 2));
    send_item(ACT_ADD, 8'h5A, 16'd7);
    send_item(ACT_TICK, 8'hFF, 16'hFFFF);
  endtask

  // Equal wake times, middle and tail inserts, delta hand-off on remove
  task automatic test_ordering();
    send_item(ACT_ADD, 8'hAA, 16'd5);
    send_item(ACT_ADD, 8'h55, 16'd5);
    send_item(ACT_ADD, 8'hC3, 16'hFFFF);
    send_item(ACT_ADD, 8'h81, 16'd7);
    send_item(ACT_TICK, 8'h00, 16'h0000);
    send_item(ACT_RM_TAIL, 8'h00, 16'h0000);
    send_item(ACT_RM_HEAD, 8'h00, 16'h0000);
    send_item(ACT_RM_HEAD, 8'h00, 16'h0000);
    send_item(ACT_RM_HEAD, 8'h00, 16'h0000);
  endtask

  task automatic test_empty_list();
    send_item(ACT_RM_HEAD, 8'hFF, 16'hFFFF);
    send_item(ACT_RM_TAIL, 8'hFF, 16'hFFFF);
    send_item(ACT_TICK, 8'h00, 16'h0000);
  endtask

  // Random traffic in four idling phases
  task automatic test_random_traffic();
    int src_pct [4]  = '{0, 55, 0, 15};
    int sink_pct [4] = '{0, 0, 55, 15};
    int ph;
    int sent;
    int burst;
    logic [DELTA_W-1:0] d;
    for (ph = 0; ph < 4; ph++) begin
      src_idle_pct   = src_pct[ph];
      sink_stall_pct = sink_pct[ph];
      sent = 0;
      while (sent < 55) begin
        if ($urandom_range(9) == 0) begin
          // several sleepers with one wake time, then tick them out together
          burst = $urandom_range(6, 2);
          d = DELTA_W'($urandom_range(3, 1));
          repeat (burst) send_item(ACT_ADD, PID_W'($urandom_range(255)), d);
          repeat (d + 1)
            send_item(ACT_TICK, PID_W'($urandom_range(255)),
                      DELTA_W'($urandom_range(65535)));
          sent += burst + d + 1;
        end else begin
          send_item(pick_action(), PID_W'($urandom_range(255)), pick_delay());
          sent++;
        end
      end
    end
    src_idle_pct   = 0;
    sink_stall_pct = 0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_full_list();
    test_ordering();
    test_empty_list();
    test_random_traffic();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("Sent %0d items: %0d adds, %0d ticks, %0d removes; %0d results checked",
             items_sent, n_adds, n_ticks, n_removes, results_checked);
    $display("Released %0d sleepers by tick, peak list fill %0d of %0d",
             n_released, peak_fill, QDEPTH);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Timed out with %0d results still pending", pending_results.size());
    $display("FAILURE");
    $finish;
  end

endmodule
